### rtl/core/rotl_pkg.sv
// Shared types and constants for the rumble on-time limiter.
package rotl_pkg;

  localparam int CHANNELS = 4;
  localparam int MASK_W   = 4;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] MAX_ON_RESET   = 32'd30000;
  localparam logic [TIME_W-1:0] COOLDOWN_RESET = 32'd30000;
  localparam logic [TIME_W-1:0] GAP_RESET      = 32'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ON   = 2'd0,
    CFG_COOLDOWN = 2'd1,
    CFG_GAP      = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [TIME_W-1:0] max_on_ms;
    logic [TIME_W-1:0] cooldown_ms;
    logic [TIME_W-1:0] gap_ms;
  } cfg_t;

  typedef struct packed {
    logic              step;
    logic [TIME_W-1:0] now_ms;
    logic              request;
  } chan_cmd_t;

endpackage

### rtl/core/rotl_cfg.sv
// Configuration register file for the rumble on-time limiter.
module rotl_cfg
  import rotl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_on_ms   <= MAX_ON_RESET;
      regs.cooldown_ms <= COOLDOWN_RESET;
      regs.gap_ms      <= GAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_ON:   regs.max_on_ms   <= cfg_data;
        CFG_COOLDOWN: regs.cooldown_ms <= cfg_data;
        CFG_GAP:      regs.gap_ms      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

### rtl/core/rotl_channel.sv
// Per-controller session, gap and cooldown tracking.
module rotl_channel
  import rotl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  chan_cmd_t cmd,
  output logic      off
);

  logic              session_active, session_active_next;
  logic              cooling_down, cooling_down_next;
  logic              gap_armed, gap_armed_next;
  logic [TIME_W-1:0] session_start, session_start_next;
  logic [TIME_W-1:0] cooldown_start, cooldown_start_next;
  logic [TIME_W-1:0] gap_start, gap_start_next;

  logic [TIME_W-1:0] on_elapsed, gap_elapsed, cool_elapsed;

  // Wrapping differences; only meaningful when the matching flag is set.
  assign on_elapsed   = cmd.now_ms - session_start;
  assign gap_elapsed  = cmd.now_ms - gap_start;
  assign cool_elapsed = cmd.now_ms - cooldown_start;

  always_comb begin
    session_active_next = session_active;
    cooling_down_next   = cooling_down;
    gap_armed_next      = gap_armed;
    session_start_next  = session_start;
    cooldown_start_next = cooldown_start;
    gap_start_next      = gap_start;
    if (!cooling_down) begin
      if (cmd.request) begin
        session_active_next = 1'b1;
        if (!session_active) begin
          session_start_next = cmd.now_ms;
        end else if (on_elapsed > cfg.max_on_ms) begin
          cooling_down_next   = 1'b1;
          cooldown_start_next = cmd.now_ms;
        end
        gap_armed_next = 1'b0;
      end else if (session_active) begin
        if (!gap_armed) begin
          gap_armed_next = 1'b1;
          gap_start_next = cmd.now_ms;
        end else if (gap_elapsed > cfg.gap_ms) begin
          gap_armed_next      = 1'b0;
          session_active_next = 1'b0;
        end
      end
    end else if (cool_elapsed > cfg.cooldown_ms) begin
      cooling_down_next   = 1'b0;
      session_active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active <= 1'b0;
      cooling_down   <= 1'b0;
      gap_armed      <= 1'b0;
    end else if (cmd.step) begin
      session_active <= session_active_next;
      cooling_down   <= cooling_down_next;
      gap_armed      <= gap_armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      session_start  <= session_start_next;
      cooldown_start <= cooldown_start_next;
      gap_start      <= gap_start_next;
    end
  end

  assign off = cooling_down;

  // A cooldown only ever runs inside a session.
  a_cool_in_session: assert property (@(posedge clk) disable iff (rst)
    cooling_down |-> session_active)
    else $error("cooldown without an active session");

  // The gap timer is cleared whenever a cooldown is entered and cannot re-arm.
  a_cool_no_gap: assert property (@(posedge clk) disable iff (rst)
    cooling_down |-> !gap_armed)
    else $error("gap timer armed during cooldown");

endmodule

### rtl/core/rumble_on_time_limiter.sv
// Top level of the rumble on-time limiter: input stage, channels and result stage.
//
// The block accepts one frame item per clock cycle while the result side keeps
// taking results, and returns one disable mask for each item, in order. An
// input transfer lands in an input register; once the result register is free
// or is being emptied, the per-controller logic (three 32-bit wrapping
// subtract-and-compare paths per controller, which set the cycle time) updates
// the controller state and the mask is written into the result register. The
// input register and the result register together hold two items, so a new
// input transfer is still taken while one finished result waits to be taken.
// Bit i of the mask is set while controller i is in cooldown (including the
// frame in which the cooldown ends, but not the frame in which it begins), or
// whenever any of the three inhibit inputs is set; the inhibits never alter the
// controller state. Configuration writes take effect at once and are meant to
// be made while no item is in flight.
module rumble_on_time_limiter
  import rotl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TIME_W-1:0]    now_ms,
  input  logic [MASK_W-1:0]    rumble_request,
  input  logic                 media_ejected,
  input  logic                 external_inhibit,
  input  logic                 level_inhibit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MASK_W-1:0]    disable_mask
);

  cfg_t cfg;

  // Input stage registers.
  logic              s1_valid;
  logic [TIME_W-1:0] s1_now;
  logic [MASK_W-1:0] s1_req;
  logic              s1_inhibit;
  logic              s1_move;

  logic [CHANNELS-1:0] chan_off;
  logic [MASK_W-1:0]   mask_next;

  rotl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The input stage moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now     <= now_ms;
      s1_req     <= rumble_request;
      s1_inhibit <= media_ejected | external_inhibit | level_inhibit;
    end
  end

  // One tracker per controller. Controllers beyond the request width see no
  // request and do not appear in the mask.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    chan_cmd_t cmd;
    if (i < MASK_W) begin : g_req
      assign cmd.request = s1_req[i];
    end else begin : g_noreq
      assign cmd.request = 1'b0;
    end
    assign cmd.step   = s1_move;
    assign cmd.now_ms = s1_now;

    rotl_channel u_chan (
      .clk (clk),
      .rst (rst),
      .cfg (cfg),
      .cmd (cmd),
      .off (chan_off[i])
    );
  end

  // The mask uses the cooldown state as it stood before this frame's update.
  // Mask bits with no controller behind them stay clear.
  for (genvar j = 0; j < MASK_W; j++) begin : g_mask
    if (j < CHANNELS) begin : g_live
      assign mask_next[j] = chan_off[j] | s1_inhibit;
    end else begin : g_dead
      assign mask_next[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      disable_mask <= mask_next;
    end
  end

  // An empty input stage always takes a transfer.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stage empty but not ready");

  // With both stages full and the result stalled, no further transfer is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("transfer accepted with both stages full");

  // An inhibited frame yields a mask with every bit set.
  a_inhibit_mask: assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1_inhibit) |=> (out_valid && (&disable_mask)))
    else $error("inhibited frame did not disable every controller");

  // A frame reaching the result stage always makes a result visible.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("frame left the input stage without a result");

endmodule
